// ===== hdl/odometry_dead_reckoning_macros.svh =====
// ----------------------------------------------------------------------------
// odometry_dead_reckoning_macros
// assertion macros for the dead reckoning block
// ----------------------------------------------------------------------------
`ifndef ODOMETRY_DEAD_RECKONING_MACROS_SVH
`define ODOMETRY_DEAD_RECKONING_MACROS_SVH

// implication checked on every clock edge outside reset
`define ODR_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// next-cycle implication checked on every clock edge outside reset
`define ODR_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== hdl/odr_pkg.sv =====
// ----------------------------------------------------------------------------
// odr_pkg
// types, constants and tables shared by the dead reckoning block
// ----------------------------------------------------------------------------
package odr_pkg;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] heading;
    logic signed [31:0] wheel_distance;
    logic signed [23:0] speed;
  } odr_in_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [23:0] speed_out;
  } odr_out_t;

  // work queued between front and back
  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [31:0] step;
    logic signed [23:0] speed;
  } odr_job_t;

  localparam logic CmdHeading  = 1'b0;
  localparam logic CmdOdometer = 1'b1;

  localparam int QDepth   = 2;
  localparam int QPtrW    = 1;
  localparam int IterN    = 16;
  localparam int IterW    = 4;

  localparam logic signed [27:0] Pi24     = 28'sd52707179;
  localparam logic signed [27:0] HalfPi24 = 28'sd26353589;
  localparam logic signed [31:0] CordicGain = 32'sd326016437;
  localparam logic signed [47:0] PosMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] PosMin = 48'sh8000_0000_0000;

  function automatic logic signed [27:0] atan_lut(input logic [IterW-1:0] i);
    logic signed [27:0] r;
    case (i)
      4'd0:    r = 28'sd13176795;
      4'd1:    r = 28'sd7778716;
      4'd2:    r = 28'sd4110060;
      4'd3:    r = 28'sd2086331;
      4'd4:    r = 28'sd1047214;
      4'd5:    r = 28'sd524117;
      4'd6:    r = 28'sd262123;
      4'd7:    r = 28'sd131069;
      4'd8:    r = 28'sd65536;
      4'd9:    r = 28'sd32768;
      4'd10:   r = 28'sd16384;
      4'd11:   r = 28'sd8192;
      4'd12:   r = 28'sd4096;
      4'd13:   r = 28'sd2048;
      4'd14:   r = 28'sd1024;
      default: r = 28'sd512;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/odr_front.sv =====
// ----------------------------------------------------------------------------
// odr_front
// takes input transactions, keeps heading and last distance, queues jobs
// ----------------------------------------------------------------------------
module odr_front import odr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  odr_in_t  in_data,
  output logic     job_valid,
  input  logic     job_take,
  output odr_job_t job
);

  logic signed [15:0] yaw_angle;
  logic        [31:0] last_distance;
  logic               started;
  odr_job_t           q [QDepth];
  logic [QPtrW-1:0]   wr_ptr, rd_ptr;
  logic [QPtrW:0]     count;
  logic               acc, enq, deq;

  assign full      = (count == (QPtrW + 1)'(QDepth));
  assign acc       = push && !full;
  assign enq       = acc && (in_data.cmd == CmdOdometer) && started;
  assign deq       = job_take && job_valid;
  assign job_valid = (count != '0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_angle     <= '0;
      last_distance <= '0;
      started       <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (acc) begin
        if (in_data.cmd == CmdHeading) begin
          yaw_angle <= in_data.heading;
        end else begin
          last_distance <= in_data.wheel_distance;
          started       <= 1'b1;
        end
      end
      if (enq) begin
        q[wr_ptr].yaw   <= yaw_angle;
        q[wr_ptr].step  <= in_data.wheel_distance - last_distance;
        q[wr_ptr].speed <= in_data.speed;
        wr_ptr          <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{QPtrW{1'b0}}, enq} - {{QPtrW{1'b0}}, deq};
    end
  end

endmodule

// ===== hdl/odr_back.sv =====
// ----------------------------------------------------------------------------
// odr_back
// iterative cordic for yaw and half yaw, then position update and output
// ----------------------------------------------------------------------------
module odr_back import odr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  output logic     job_take,
  input  odr_job_t job,
  output logic     empty,
  input  logic     pop,
  output odr_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_ITER, S_ROUND, S_MUL, S_ACC, S_OUT
  } state_t;

  state_t state;
  odr_job_t cur;
  // two cordic lanes: full yaw (a) and half yaw (b)
  logic signed [31:0] xa, ya, xb, yb;
  logic signed [27:0] za, zb;
  logic               nega, negb;
  logic [IterW-1:0]   it;
  logic signed [15:0] ca, sa, cb, sb;
  logic signed [47:0] px, py;
  logic signed [47:0] acc_x, acc_y;

  function automatic logic signed [27:0] reduce(input logic signed [27:0] z,
                                                output logic neg);
    logic signed [27:0] r;
    r = z;
    if (r > Pi24) r = r - (Pi24 <<< 1);
    else if (r < -Pi24) r = r + (Pi24 <<< 1);
    neg = 1'b0;
    if (r > HalfPi24) begin
      r = r - Pi24;
      neg = 1'b1;
    end else if (r < -HalfPi24) begin
      r = r + Pi24;
      neg = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] rnd(input logic signed [31:0] v,
                                             input logic neg);
    logic signed [32:0] t;
    logic signed [17:0] q;
    logic signed [15:0] r;
    t = {v[31], v} + 33'sd16384;
    q = t[32:15];
    if (q > 18'sd16384) r = 16'sd16384;
    else if (q < -18'sd16384) r = -16'sd16384;
    else r = q[15:0];
    return neg ? -r : r;
  endfunction

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                 input logic signed [47:0] p);
    logic signed [48:0] s;
    s = {a[47], a} + {p[47], p};
    if (s > 49'(PosMax)) return PosMax;
    if (s < 49'(PosMin)) return PosMin;
    return s[47:0];
  endfunction

  logic signed [27:0] ra, rb;
  logic               na, nb;
  logic signed [47:0] mx, my;
  logic signed [27:0] at;

  always_comb begin
    ra = reduce({{1{cur.yaw[15]}}, cur.yaw, 11'd0}, na);
    rb = reduce({{2{cur.yaw[15]}}, cur.yaw, 10'd0}, nb);
    at = atan_lut(it);
    mx = (48'(cur.step) * 48'(ca) + 48'sd8192) >>> 14;
    my = (48'(cur.step) * 48'(sa) + 48'sd8192) >>> 14;
  end

  assign job_take = (state == S_IDLE) && job_valid;
  assign empty    = (state != S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc_x <= '0;
      acc_y <= '0;
      it    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          za <= ra; nega <= na;
          zb <= rb; negb <= nb;
          xa <= CordicGain; ya <= '0;
          xb <= CordicGain; yb <= '0;
          it <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          if (za >= 0) begin
            xa <= xa - (ya >>> it); ya <= ya + (xa >>> it); za <= za - at;
          end else begin
            xa <= xa + (ya >>> it); ya <= ya - (xa >>> it); za <= za + at;
          end
          if (zb >= 0) begin
            xb <= xb - (yb >>> it); yb <= yb + (xb >>> it); zb <= zb - at;
          end else begin
            xb <= xb + (yb >>> it); yb <= yb - (xb >>> it); zb <= zb + at;
          end
          it <= it + 1'b1;
          if (it == IterW'(IterN - 1)) state <= S_ROUND;
        end
        S_ROUND: begin
          ca <= rnd(xa, nega); sa <= rnd(ya, nega);
          cb <= rnd(xb, negb); sb <= rnd(yb, negb);
          state <= S_MUL;
        end
        S_MUL: begin
          px <= mx; py <= my;
          state <= S_ACC;
        end
        S_ACC: begin
          acc_x <= sat_add(acc_x, px);
          acc_y <= sat_add(acc_y, py);
          out_data.pos_x     <= sat_add(acc_x, px);
          out_data.pos_y     <= sat_add(acc_y, py);
          out_data.quat_z    <= sb;
          out_data.quat_w    <= cb;
          out_data.speed_out <= cur.speed;
          state <= S_OUT;
        end
        S_OUT: begin
          if (pop) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/odometry_dead_reckoning.sv =====
// ----------------------------------------------------------------------------
// odometry_dead_reckoning
// planar dead reckoning from heading and cumulative wheel distance
// ----------------------------------------------------------------------------
// Heading and the first odometer transaction are absorbed by the front end
// while the queue has room. Every later odometer transaction is queued (two
// deep) and the back end works through it in order: load, angle reduction,
// 16 iterations of a shared pair of cordic lanes (yaw and half yaw together),
// then rounding, the multiply and the saturating add. The pose then waits for
// pop, and the next job is loaded in the cycle after the pop, so the back end
// takes no new job until the last pose has been popped.
module odometry_dead_reckoning import odr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  odr_in_t  in_data,
  output logic     empty,
  input  logic     pop,
  output odr_out_t out_data
);

`include "odometry_dead_reckoning_macros.svh"

  logic     job_valid, job_take;
  odr_job_t job;

  odr_front u_front (
    .clk, .rst, .push, .full, .in_data, .job_valid, .job_take, .job
  );

  odr_back u_back (
    .clk, .rst, .job_valid, .job_take, .job, .empty, .pop, .out_data
  );

  `ODR_ASSERT_IMP(a_take_needs_job, clk, rst, job_take, job_valid)
  `ODR_ASSERT_NEXT(a_pop_clears, clk, rst, pop && !empty, empty)
  `ODR_ASSERT_IMP(a_quat_range, clk, rst, !empty,
    out_data.quat_w <= 16'sd16384 && out_data.quat_w >= -16'sd16384)

endmodule

// ===== sim/odometry_dead_reckoning_test.sv =====
// ----------------------------------------------------------------------------
// odometry_dead_reckoning_test
// drives heading and odometer transactions into the dead reckoning block and
// checks every pose against a fixed-point model kept in a scoreboard class
// ----------------------------------------------------------------------------
module odometry_dead_reckoning_test import odr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int   IdleLimit   = 5000;
  localparam int   HeadingMax  = 25736;

  class pose_tracker;
    odr_out_t    pending_poses[$];
    longint      yaw;
    logic [31:0] last_dist;
    bit          started;
    longint      acc_x;
    longint      acc_y;
    int          errors;
    int          checked;

    function new();
      yaw = 0;
      last_dist = 0;
      started = 0;
      acc_x = 0;
      acc_y = 0;
      errors = 0;
      checked = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // cordic sine and cosine, angle in units of 2^-24 rad, results Q1.14
    function void trig_q14(input longint ang, output longint c, output longint s);
      longint atan_steps[16] = '{13176795, 7778716, 4110060, 2086331, 1047214,
                                 524117, 262123, 131069, 65536, 32768, 16384,
                                 8192, 4096, 2048, 1024, 512};
      longint pi24;
      longint x;
      longint y;
      longint t;
      longint z;
      bit     neg;
      pi24 = 52707179;
      x = 326016437;
      y = 0;
      z = ang;
      neg = 0;
      if (z > pi24) z -= 2 * pi24;
      else if (z < -pi24) z += 2 * pi24;
      if (z > 26353589) begin
        z -= pi24;
        neg = 1;
      end else if (z < -26353589) begin
        z += pi24;
        neg = 1;
      end
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_steps[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_steps[i];
        end
        x = t;
      end
      x = clip((x + (64'sd1 <<< 14)) >>> 15, -16384, 16384);
      y = clip((y + (64'sd1 <<< 14)) >>> 15, -16384, 16384);
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    function void note(odr_in_t d);
      longint   step;
      longint   c;
      longint   s;
      longint   hc;
      longint   hs;
      odr_out_t e;
      if (d.cmd == CmdHeading) begin
        yaw = longint'(d.heading);
        return;
      end
      if (!started) begin
        last_dist = d.wheel_distance;
        started = 1;
        return;
      end
      step = longint'($signed(d.wheel_distance - last_dist));
      last_dist = d.wheel_distance;
      trig_q14(yaw * 2048, c, s);
      trig_q14(yaw * 1024, hc, hs);
      acc_x = clip(acc_x + ((step * c + (64'sd1 <<< 13)) >>> 14),
                   -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
      acc_y = clip(acc_y + ((step * s + (64'sd1 <<< 13)) >>> 14),
                   -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
      e.pos_x = acc_x[47:0];
      e.pos_y = acc_y[47:0];
      e.quat_z = hs[15:0];
      e.quat_w = hc[15:0];
      e.speed_out = d.speed;
      pending_poses.push_back(e);
    endfunction

    task report(string field, longint got, longint want);
      $display("mismatch on pose %0d: %s got %0d expected %0d", checked, field, got, want);
      errors++;
    endtask

    task check(odr_out_t got);
      odr_out_t e;
      if (pending_poses.size() == 0) begin
        report("unexpected pose, pos_x", got.pos_x, 0);
        return;
      end
      e = pending_poses.pop_front();
      if (got.pos_x !== e.pos_x) report("pos_x", got.pos_x, e.pos_x);
      if (got.pos_y !== e.pos_y) report("pos_y", got.pos_y, e.pos_y);
      if (got.quat_z !== e.quat_z) report("quat_z", got.quat_z, e.quat_z);
      if (got.quat_w !== e.quat_w) report("quat_w", got.quat_w, e.quat_w);
      if (got.speed_out !== e.speed_out) report("speed_out", got.speed_out, e.speed_out);
      checked++;
    endtask
  endclass

  logic     clk;
  logic     rst;
  logic     push;
  logic     full;
  odr_in_t  in_data;
  logic     empty;
  logic     pop;
  odr_out_t out_data;

  pose_tracker tracker = new();
  bit          quiet;
  int          idle_cycles;
  int          sent;
  logic [31:0] odo;

  odometry_dead_reckoning i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    push = 0;
    pop = 0;
    in_data = '0;
  end

  always @(negedge clk) begin
    if (rst) pop <= 0;
    else pop <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    if (!rst && push && !full) tracker.note(in_data);
    if (!rst && pop && !empty) tracker.check(out_data);
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  task send(logic cmd, logic signed [15:0] hdg, logic [31:0] distance, logic [23:0] spd);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 24) begin
      push = 0;
      @(negedge clk);
    end
    push = 1;
    in_data.cmd = cmd;
    in_data.heading = hdg;
    in_data.wheel_distance = distance;
    in_data.speed = spd;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task send_odo(logic [31:0] delta, logic [23:0] spd);
    odo = odo + delta;
    send(CmdOdometer, 16'($urandom), odo, spd);
  endtask

  task drain();
    @(negedge clk);
    push = 0;
    while (tracker.pending_poses.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    sent = 0;
    quiet = 0;
    odo = 0;
    rst = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // first odometer sample only latches, its speed is ignored
    send(CmdOdometer, 16'sd0, 32'h1234_0000, 24'h7FFFFF);
    odo = 32'h1234_0000;
    send_odo(32'h0001_0000, 24'h7FFFFF);
    send_odo(32'h0002_8000, 24'h800000);
    send(CmdHeading, 16'(HeadingMax), 32'h0, 24'h0);
    send_odo(32'h0001_0000, 24'h000001);
    send(CmdHeading, 16'(-HeadingMax), 32'hFFFF_FFFF, 24'hFFFFFF);
    send_odo(32'h0001_0000, 24'hFFFFFF);
    send(CmdHeading, 16'sd12868, 32'h0, 24'h0);
    send_odo(32'h7FFF_FFFF, 24'h0);
    send(CmdHeading, -16'sd12868, 32'h0, 24'h0);
    send_odo(32'h8000_0000, 24'h123456);
    send(CmdHeading, 16'sd25735, 32'h0, 24'h0);
    send_odo(32'hFFFF_0000, 24'h0);
    send(CmdHeading, -16'sd1, 32'h0, 24'h0);
    // wrap of the cumulative distance
    odo = 32'h7FFF_F000;
    send(CmdOdometer, 16'sd0, odo, 24'h0);
    send_odo(32'h0000_2000, 24'h0);
    send(CmdHeading, 16'sd1, 32'h0, 24'h0);
    send_odo(32'h0000_0000, 24'h0);
    drain();

    for (int n = 0; n < 550; n++) begin
      quiet = (n >= 200 && n < 280);
      if ($urandom_range(99) < 20)
        send(CmdHeading, 16'($signed($urandom_range(2 * HeadingMax)) - HeadingMax),
             $urandom, 24'($urandom));
      else if ($urandom_range(99) < 15)
        send_odo($urandom, 24'($urandom));
      else
        send_odo(32'($signed($urandom_range(2 * 32'h0004_0000)) - 32'sh0004_0000),
                 24'($urandom));
      if (n == 400) drain();
    end
    drain();

    $display("sent %0d heading and odometer transactions, checked %0d poses", sent,
             tracker.checked);
    $display("covered heading extremes, distance wrap, and random stalls on both sides");
    if (tracker.errors == 0 && tracker.pending_poses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== odometry_dead_reckoning.f =====
+incdir+hdl
hdl/odr_pkg.sv
hdl/odr_front.sv
hdl/odr_back.sv
hdl/odometry_dead_reckoning.sv
sim/odometry_dead_reckoning_test.sv
